/* rtl/dglcd_pkg.sv */
// Shared types, constants and address helper for the dual-half graphic LCD controller.
// Depends on nothing; every other file imports it.
package dglcd_pkg;

    localparam int PAGE_COUNT    = 8;
    localparam int DISPLAY_WIDTH = 128;
    localparam int HALF_COLS     = DISPLAY_WIDTH / 2;
    localparam int HALF_SIZE     = PAGE_COUNT * HALF_COLS;
    localparam int ADDR_W        = (HALF_SIZE > 1) ? $clog2(HALF_SIZE) : 1;

    localparam int PAGE_W = 3;
    localparam int COL_W  = 6;
    localparam int LINE_W = 6;

    // Command bytes and the masks that pick them out.
    localparam logic [7:0] CMD_DISPLAY_OFF = 8'h3E;
    localparam logic [7:0] CMD_DISPLAY_ON  = 8'h3F;
    localparam logic [7:0] CMD_SET_COL     = 8'h40;
    localparam logic [7:0] CMD_SET_PAGE    = 8'hB8;
    localparam logic [7:0] CMD_SET_LINE    = 8'hC0;
    localparam logic [7:0] MASK_TWO_BITS   = 8'hC0;
    localparam logic [7:0] MASK_FIVE_BITS  = 8'hF8;

    localparam logic [7:0] STATUS_OFF = 8'h20;

    // Bit positions within half_select.
    localparam int SEL_LEFT  = 0;
    localparam int SEL_RIGHT = 1;

    typedef enum logic [1:0] {
        OP_CMD        = 2'd0,
        OP_DATA_WRITE = 2'd1,
        OP_STATUS     = 2'd2,
        OP_DATA_READ  = 2'd3
    } op_t;

    typedef struct packed {
        logic       act;
        op_t        op;
        logic [7:0] value;
    } half_req_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } clear_t;

    typedef struct packed {
        logic [7:0] latch;
        logic       display_on;
    } half_stat_t;

    function automatic logic [ADDR_W-1:0] addr_of(input logic [PAGE_W-1:0] page,
                                                  input logic [COL_W-1:0] col);
        logic [31:0] full;
        full = 32'(page) * 32'(HALF_COLS) + 32'(col);
        return full[ADDR_W-1:0];
    endfunction

endpackage

/* rtl/dglcd_half.sv */
// One display half: its byte RAM, address registers and output latch.
// Depends on dglcd_pkg.
module dglcd_half (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dglcd_pkg::half_req_t  req,
    input  dglcd_pkg::clear_t     clr,
    output dglcd_pkg::half_stat_t stat
);
    import dglcd_pkg::*;

    logic [7:0]        mem [HALF_SIZE];
    logic [7:0]        rdata_reg;

    logic [PAGE_W-1:0] page_reg, page_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic              on_reg, on_next;
    logic [7:0]        latch_reg, latch_next;
    logic              rd_pend_reg, rd_pend_next;
    logic              rd_ok_reg, rd_ok_next;

    logic              addr_ok;
    logic [ADDR_W-1:0] cur_addr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;

    assign addr_ok  = ({1'b0, page_reg} < (PAGE_W + 1)'(PAGE_COUNT)) &&
                      ({1'b0, col_reg} < (COL_W + 1)'(HALF_COLS));
    assign cur_addr = addr_of(page_reg, col_reg);

    assign we    = clr.en || (req.act && req.op == OP_DATA_WRITE && addr_ok);
    assign waddr = clr.en ? clr.addr : cur_addr;
    assign wdata = clr.en ? 8'h00 : req.value;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[cur_addr];
    end

    always_comb
    begin
        page_next    = page_reg;
        col_next     = col_reg;
        line_next    = line_reg;
        on_next      = on_reg;
        latch_next   = latch_reg;
        rd_pend_next = 1'b0;
        rd_ok_next   = rd_ok_reg;

        // The RAM word for a data read arrives in rdata_reg in the cycle after the access.
        if (rd_pend_reg)
        begin
            latch_next = rd_ok_reg ? rdata_reg : 8'h00;
        end

        if (req.act)
        begin
            unique case (req.op)
                OP_CMD:
                begin
                    priority if (req.value == CMD_DISPLAY_OFF)
                    begin
                        on_next = 1'b0;
                    end
                    else if (req.value == CMD_DISPLAY_ON)
                    begin
                        on_next = 1'b1;
                    end
                    else if ((req.value & MASK_TWO_BITS) == CMD_SET_COL)
                    begin
                        col_next = req.value[COL_W-1:0];
                    end
                    else if ((req.value & MASK_FIVE_BITS) == CMD_SET_PAGE)
                    begin
                        page_next = req.value[PAGE_W-1:0];
                    end
                    else if ((req.value & MASK_TWO_BITS) == CMD_SET_LINE)
                    begin
                        line_next = req.value[LINE_W-1:0];
                    end
                    else
                    begin
                        line_next = line_reg;
                    end
                end
                OP_DATA_WRITE:
                begin
                    col_next = col_reg + 1'b1;
                end
                OP_STATUS:
                begin
                    col_next = col_reg;
                end
                OP_DATA_READ:
                begin
                    rd_pend_next = 1'b1;
                    rd_ok_next   = addr_ok;
                    col_next     = col_reg + 1'b1;
                end
                default:
                begin
                    col_next = col_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_reg    <= '0;
            col_reg     <= '0;
            line_reg    <= '0;
            on_reg      <= 1'b0;
            latch_reg   <= '0;
            rd_pend_reg <= 1'b0;
            rd_ok_reg   <= 1'b0;
        end
        else
        begin
            page_reg    <= page_next;
            col_reg     <= col_next;
            line_reg    <= line_next;
            on_reg      <= on_next;
            latch_reg   <= latch_next;
            rd_pend_reg <= rd_pend_next;
            rd_ok_reg   <= rd_ok_next;
        end
    end

    assign stat.latch      = latch_reg;
    assign stat.display_on = on_reg;

endmodule

/* rtl/dglcd_ctrl.sv */
// Access control: clearing sweep after reset, read interlock, result register.
// Depends on dglcd_pkg.
module dglcd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [1:0]            half_select,
    input  logic [1:0]            operation,
    input  logic [7:0]            write_value,
    input  dglcd_pkg::half_stat_t stat_left,
    input  dglcd_pkg::half_stat_t stat_right,
    output logic                  busy,
    output logic                  valid,
    output logic [7:0]            read_value,
    output dglcd_pkg::half_req_t  req_left,
    output dglcd_pkg::half_req_t  req_right,
    output dglcd_pkg::clear_t     clr
);
    import dglcd_pkg::*;

    logic              clearing_reg, clearing_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic              pend_reg, pend_next;
    logic              valid_reg, valid_next;
    logic [7:0]        result_reg, result_next;

    logic              accept;
    op_t               op;
    half_stat_t        first;
    logic              any_sel;

    assign busy    = clearing_reg || pend_reg;
    assign accept  = start && !busy;
    assign op      = op_t'(operation);
    assign any_sel = half_select[SEL_LEFT] || half_select[SEL_RIGHT];
    // With both halves selected, reads answer from the left half.
    assign first   = half_select[SEL_LEFT] ? stat_left : stat_right;

    assign req_left.act    = accept && half_select[SEL_LEFT];
    assign req_left.op     = op;
    assign req_left.value  = write_value;
    assign req_right.act   = accept && half_select[SEL_RIGHT];
    assign req_right.op    = op;
    assign req_right.value = write_value;

    assign clr.en   = clearing_reg;
    assign clr.addr = clr_cnt_reg;

    always_comb
    begin
        clearing_next = clearing_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == ADDR_W'(HALF_SIZE - 1))
            begin
                clearing_next = 1'b0;
            end
        end

        pend_next   = accept && any_sel && op == OP_DATA_READ;
        valid_next  = accept;
        result_next = 8'h00;
        if (any_sel)
        begin
            unique case (op)
                OP_STATUS:    result_next = first.display_on ? 8'h00 : STATUS_OFF;
                OP_DATA_READ: result_next = first.latch;
                default:      result_next = 8'h00;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            pend_reg     <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_cnt_reg  <= clr_cnt_next;
            pend_reg     <= pend_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign valid      = valid_reg;
    assign read_value = result_reg;

endmodule

/* rtl/dual_half_graphic_lcd_controller.sv */
// Dual-half graphic LCD controller: each word gives one result, strobed by valid in the
// cycle after it is taken. A data read also holds busy high until the RAM word reaches
// the output latch. After reset both half RAMs are cleared (one word per half per cycle)
// with busy high. Results cannot be stalled.
module dual_half_graphic_lcd_controller (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] half_select,
    input  logic [1:0] operation,
    input  logic [7:0] write_value,
    output logic       valid,
    output logic [7:0] read_value
);
    import dglcd_pkg::*;

    half_req_t  req_left, req_right;
    half_stat_t stat_left, stat_right;
    clear_t     clr;

    dglcd_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .half_select (half_select),
        .operation   (operation),
        .write_value (write_value),
        .stat_left   (stat_left),
        .stat_right  (stat_right),
        .busy        (busy),
        .valid       (valid),
        .read_value  (read_value),
        .req_left    (req_left),
        .req_right   (req_right),
        .clr         (clr)
    );

    dglcd_half u_left (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_left),
        .clr   (clr),
        .stat  (stat_left)
    );

    dglcd_half u_right (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_right),
        .clr   (clr),
        .stat  (stat_right)
    );

endmodule
